>>> rtl/hsv_to_rgb_converter_assert.svh
// Assertion macros shared by the checker of the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define HSV_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hsv_to_rgb_converter: assertion failed");

// Next-cycle implication, checked only while out of reset.
`define HSV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsv_to_rgb_converter: assertion failed");

`endif

>>> rtl/hsv_pkg.sv
// Types and constants of the HSV to RGB converter.
package hsv_pkg;

    localparam int HUE_W   = 16;
    localparam int SV_W    = 9;
    localparam int CHAN_W  = 8;
    localparam int U_W     = 17;   // offset hue, always positive
    localparam int Q_W     = 8;    // estimated quotient of hue by 360
    localparam int DEG_W   = 9;    // hue in 0..359
    localparam int REM_W   = 6;    // remainder in 0..59
    localparam int A_W     = 14;   // factors of the form 15360 - s*x
    localparam int N_W     = 22;   // component numerators
    localparam int STAGES  = 6;

    // 360 * 92: moves every 16-bit signed hue to a positive value.
    localparam logic [U_W-1:0] HUE_OFFSET  = U_W'(33120);
    // floor(2^20 / 360); the estimate is at most one below the true quotient.
    localparam logic [11:0]    RECIP_360   = 12'd2912;
    localparam int             RECIP_SHIFT = 20;
    localparam logic [DEG_W-1:0] DEG_FULL  = DEG_W'(360);
    localparam logic [REM_W-1:0] DEG_SECTOR = REM_W'(60);
    localparam logic [SV_W-1:0]  SV_ONE    = SV_W'(256);
    localparam logic [A_W-1:0]   ONE_Q     = A_W'(15360);
    // x*255 / (15 * 2^18) equals x*17 / 2^18.
    localparam logic [4:0]       CHAN_MUL  = 5'd17;
    localparam int               CHAN_SHIFT = 18;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_hue_ctl;

endpackage

>>> rtl/hsv_if.sv
// Valid/ready channels for HSV items in and RGB items out.
interface hsv_in_if;
    import hsv_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [HUE_W-1:0]  hue_deg;
    logic        [SV_W-1:0]   saturation;
    logic        [SV_W-1:0]   brightness;

    modport source (output valid, hue_deg, saturation, brightness, input ready);
    modport sink   (input valid, hue_deg, saturation, brightness, output ready);
endinterface

interface hsv_out_if;
    import hsv_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> rtl/hsv_to_rgb_converter.sv
// Top level of the pipelined HSV to RGB converter.
//
//   channel  | dir | payload                               | handshake
//   i_pix    | in  | hue_deg s16, saturation u9, brightness u9 | valid/ready
//   o_pix    | out | red u8, green u8, blue u8             | valid/ready
//
// Six register stages: hue offset and quotient estimate, modulo 360, sector,
// the p/q/t factors, the component numerators, and the channel output register.
// One item per cycle is taken while the output is not stalled.
// Each stage has its own valid bit and takes a new item whenever it is empty
// or its content moves on, so bubbles close up while the output is stalled.
// Reset clears the valid bits only.
module hsv_to_rgb_converter
    import hsv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    hsv_in_if.sink    i_pix,
    hsv_out_if.source o_pix
);

    logic [STAGES-1:0] r_vld, n_vld;
    logic [STAGES-1:0] w_rdy;
    logic [STAGES-1:0] w_ld;
    t_hue_ctl          w_hue_ctl;

    logic [SV_W-1:0]   w_s_clamp, w_v_clamp;
    logic [SV_W-1:0]   r_s1, r_s2, r_s3;
    logic [SV_W-1:0]   r_v1, r_v2, r_v3, r_v4;

    t_sector           w_sector;
    logic [REM_W-1:0]  w_rem;
    t_sector           r_sec4, r_sec5;
    logic [A_W-1:0]    r_ap, r_aq, r_at, n_ap, n_aq, n_at;
    logic [N_W-1:0]    r_nv, r_np, r_nq, r_nt, n_nv, n_np, n_nq, n_nt;
    logic [CHAN_W-1:0] w_cv, w_cp, w_cq, w_ct;
    logic [CHAN_W-1:0] r_red, r_green, r_blue, n_red, n_green, n_blue;

    // Stage ready ripples back from the output; a stage loads when it can
    // take an item and the stage before it holds one.
    always_comb begin
        w_rdy[STAGES-1] = !r_vld[STAGES-1] || o_pix.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_ld[0] = w_rdy[0] && i_pix.valid;
        n_vld[0] = w_rdy[0] ? i_pix.valid : r_vld[0];
        for (int k = 1; k < STAGES; k++) begin
            w_ld[k]  = w_rdy[k] && r_vld[k-1];
            n_vld[k] = w_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_hue_ctl = '{ld1: w_ld[0], ld2: w_ld[1], ld3: w_ld[2]};

    hsv_hue_unit u_hue (
        .i_clk     (i_clk),
        .i_ctl     (w_hue_ctl),
        .i_hue_deg (i_pix.hue_deg),
        .o_sector  (w_sector),
        .o_rem     (w_rem)
    );

    assign w_s_clamp = (i_pix.saturation > SV_ONE) ? SV_ONE : i_pix.saturation;
    assign w_v_clamp = (i_pix.brightness > SV_ONE) ? SV_ONE : i_pix.brightness;

    // Stage 4 factors: p is (1-s)*60, q is 15360 - s*r, t is 15360 - s*(60-r).
    always_comb begin
        n_ap = A_W'((SV_ONE - r_s3) * A_W'(DEG_SECTOR));
        n_aq = ONE_Q - A_W'(r_s3 * A_W'(w_rem));
        n_at = ONE_Q - A_W'(r_s3 * A_W'(DEG_SECTOR - w_rem));
    end

    // Stage 5 numerators over the common denominator 256 * 15360.
    always_comb begin
        n_nv = N_W'(r_v4 * N_W'(ONE_Q));
        n_np = N_W'(r_v4 * N_W'(r_ap));
        n_nq = N_W'(r_v4 * N_W'(r_aq));
        n_nt = N_W'(r_v4 * N_W'(r_at));
    end

    // Stage 6: scale to 0..255 and order the channels by sector.
    always_comb begin
        w_cv = CHAN_W'(((N_W+5)'(r_nv) * (N_W+5)'(CHAN_MUL)) >> CHAN_SHIFT);
        w_cp = CHAN_W'(((N_W+5)'(r_np) * (N_W+5)'(CHAN_MUL)) >> CHAN_SHIFT);
        w_cq = CHAN_W'(((N_W+5)'(r_nq) * (N_W+5)'(CHAN_MUL)) >> CHAN_SHIFT);
        w_ct = CHAN_W'(((N_W+5)'(r_nt) * (N_W+5)'(CHAN_MUL)) >> CHAN_SHIFT);
        case (r_sec5)
            SEC_YEL_GRN: begin
                n_red = w_cq; n_green = w_cv; n_blue = w_cp;
            end
            SEC_GRN_CYN: begin
                n_red = w_cp; n_green = w_cv; n_blue = w_ct;
            end
            SEC_CYN_BLU: begin
                n_red = w_cp; n_green = w_cq; n_blue = w_cv;
            end
            SEC_BLU_MAG: begin
                n_red = w_ct; n_green = w_cp; n_blue = w_cv;
            end
            SEC_MAG_RED: begin
                n_red = w_cv; n_green = w_cp; n_blue = w_cq;
            end
            default: begin
                n_red = w_cv; n_green = w_ct; n_blue = w_cp;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_s1 <= w_s_clamp;
            r_v1 <= w_v_clamp;
        end
        if (w_ld[1]) begin
            r_s2 <= r_s1;
            r_v2 <= r_v1;
        end
        if (w_ld[2]) begin
            r_s3 <= r_s2;
            r_v3 <= r_v2;
        end
        if (w_ld[3]) begin
            r_ap   <= n_ap;
            r_aq   <= n_aq;
            r_at   <= n_at;
            r_sec4 <= w_sector;
            r_v4   <= r_v3;
        end
        if (w_ld[4]) begin
            r_nv   <= n_nv;
            r_np   <= n_np;
            r_nq   <= n_nq;
            r_nt   <= n_nt;
            r_sec5 <= r_sec4;
        end
        if (w_ld[5]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign i_pix.ready = w_rdy[0];
    assign o_pix.valid = r_vld[STAGES-1];
    assign o_pix.red   = r_red;
    assign o_pix.green = r_green;
    assign o_pix.blue  = r_blue;

endmodule

>>> rtl/hsv_hue_unit.sv
// Three-stage hue reduction: modulo 360, then sector and remainder.
module hsv_hue_unit
    import hsv_pkg::*;
(
    input  logic                    i_clk,
    input  t_hue_ctl                i_ctl,
    input  logic signed [HUE_W-1:0] i_hue_deg,
    output t_sector                 o_sector,
    output logic [REM_W-1:0]        o_rem
);

    logic [U_W-1:0]   r_u, n_u;
    logic [Q_W-1:0]   r_q0, n_q0;
    logic [DEG_W-1:0] r_deg, n_deg;
    t_sector          r_sector, n_sector;
    logic [REM_W-1:0] r_rem, n_rem;

    logic [U_W+11:0]  w_prod;
    logic [DEG_W:0]   w_deg0;
    logic [DEG_W-1:0] w_base;

    // Stage 1: positive offset and reciprocal estimate of the quotient.
    always_comb begin
        n_u    = {i_hue_deg[HUE_W-1], i_hue_deg} + HUE_OFFSET;
        w_prod = (U_W+12)'(n_u) * (U_W+12)'(RECIP_360);
        n_q0   = w_prod[RECIP_SHIFT +: Q_W];
    end

    // Stage 2: remainder is below 720, so one correction step finishes it.
    always_comb begin
        w_deg0 = (DEG_W+1)'(r_u - U_W'(r_q0 * U_W'(DEG_FULL)));
        if (w_deg0 >= (DEG_W+1)'(DEG_FULL)) begin
            n_deg = DEG_W'(w_deg0 - (DEG_W+1)'(DEG_FULL));
        end else begin
            n_deg = DEG_W'(w_deg0);
        end
    end

    // Stage 3: sector by comparison against multiples of 60.
    always_comb begin
        if (r_deg >= DEG_W'(300)) begin
            n_sector = SEC_MAG_RED;
            w_base   = DEG_W'(300);
        end else if (r_deg >= DEG_W'(240)) begin
            n_sector = SEC_BLU_MAG;
            w_base   = DEG_W'(240);
        end else if (r_deg >= DEG_W'(180)) begin
            n_sector = SEC_CYN_BLU;
            w_base   = DEG_W'(180);
        end else if (r_deg >= DEG_W'(120)) begin
            n_sector = SEC_GRN_CYN;
            w_base   = DEG_W'(120);
        end else if (r_deg >= DEG_W'(DEG_SECTOR)) begin
            n_sector = SEC_YEL_GRN;
            w_base   = DEG_W'(DEG_SECTOR);
        end else begin
            n_sector = SEC_RED_YEL;
            w_base   = '0;
        end
        n_rem = REM_W'(r_deg - w_base);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_u  <= n_u;
            r_q0 <= n_q0;
        end
        if (i_ctl.ld2) begin
            r_deg <= n_deg;
        end
        if (i_ctl.ld3) begin
            r_sector <= n_sector;
            r_rem    <= n_rem;
        end
    end

    assign o_sector = r_sector;
    assign o_rem    = r_rem;

endmodule

>>> rtl/hsv_checker.sv
// Port-level checker for the HSV to RGB converter, bound to the top level.
`include "hsv_to_rgb_converter_assert.svh"

module hsv_checker
    import hsv_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CHAN_W-1:0] i_red,
    input logic [CHAN_W-1:0] i_green,
    input logic [CHAN_W-1:0] i_blue
);

    logic [3*CHAN_W-1:0] w_rgb;

    assign w_rgb = {i_red, i_green, i_blue};

    // A stalled result stays on the port until it is taken.
    `HSV_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)

    `HSV_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(w_rgb))

    // With nothing waiting at the output, every stage can move, so input is open.
    `HSV_ASSERT_IMPLY(a_ready_when_empty, !i_out_valid, i_in_ready)

    // No item comes out in the first cycle after reset.
    `HSV_ASSERT_IMPLY(a_none_after_reset, $past(!i_rst_n), !i_out_valid)

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_red       (o_pix.red),
    .i_green     (o_pix.green),
    .i_blue      (o_pix.blue)
);
